FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/sha1_pkg.sv
// ---------------------------------------------------------------------------
// SHA-1 package
// Types, constants and controller/datapath command structs.
// ---------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned ROUNDS        = 80;
    localparam int unsigned BLOCK_BYTES   = 64;
    localparam int unsigned DIGEST_WORDS  = 5;

    localparam logic [5:0] FILL_LAST      = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] FILL_LEN_START = 6'(BLOCK_BYTES - 8);
    localparam logic [6:0] ROUND_LAST     = 7'(ROUNDS - 1);
    localparam logic [6:0] ROUND_PH1      = 7'd20;
    localparam logic [6:0] ROUND_PH2      = 7'd40;
    localparam logic [6:0] ROUND_PH3      = 7'd60;
    localparam logic [2:0] LAST_WORD_IDX  = 3'(DIGEST_WORDS - 1);

    localparam logic [7:0] PAD_MARKER     = 8'h80;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_TABLE [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_UPDATE,
        S_PAD80,
        S_PADZ,
        S_PADL,
        S_DIGEST
    } state_t;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } phase_t;

    typedef struct packed {
        logic      shift_en;   // push one byte into the block register
        byte_sel_t byte_sel;
        logic [2:0] len_idx;   // length byte, 0 = most significant
        logic      len_add;    // count 8 more message bits
        logic      init_work;  // load a..e from chaining value
        logic      round_en;
        phase_t    phase;
        logic      chain_add;  // fold a..e into chaining value
        logic      finish;     // capture digest, restart chaining value
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

FILE: design/sha1_ctrl.sv
// ---------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds and digest hand-over.
// ---------------------------------------------------------------------------
module sha1_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_tuser,
    input  logic           s_tlast,
    input  sha1_pkg::sts_t sts,
    output sha1_pkg::cmd_t cmd
);
    import sha1_pkg::*;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [5:0] fill_reg, fill_next;
    logic [6:0] round_reg, round_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.byte_sel = SEL_INPUT;
        cmd.phase    = PH_CH;
        cmd.len_idx  = fill_reg[2:0];

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = s_tlast ? S_PAD80 : S_IDLE;
                    if (s_tuser) begin
                        cmd.shift_en = 1'b1;
                        cmd.len_add  = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                        if (fill_reg == FILL_LAST) begin
                            cmd.init_work = 1'b1;
                            ret_next      = s_tlast ? S_PAD80 : S_IDLE;
                            state_next    = S_ROUND;
                        end
                    end
                end
            end
            S_PAD80: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_PAD80;
                fill_next    = fill_reg + 6'd1;
                state_next   = S_PADZ;
                if (fill_reg == FILL_LAST) begin
                    cmd.init_work = 1'b1;
                    ret_next      = S_PADZ;
                    state_next    = S_ROUND;
                end
            end
            S_PADZ: begin
                if (fill_reg == FILL_LEN_START) begin
                    state_next = S_PADL;
                end else begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    fill_next    = fill_reg + 6'd1;
                    if (fill_reg == FILL_LAST) begin
                        cmd.init_work = 1'b1;
                        ret_next      = S_PADZ;
                        state_next    = S_ROUND;
                    end
                end
            end
            S_PADL: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = SEL_LEN;
                fill_next    = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST) begin
                    cmd.init_work = 1'b1;
                    ret_next      = S_DIGEST;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                if (round_reg < ROUND_PH1) begin
                    cmd.phase = PH_CH;
                end else if (round_reg < ROUND_PH2) begin
                    cmd.phase = PH_PAR1;
                end else if (round_reg < ROUND_PH3) begin
                    cmd.phase = PH_MAJ;
                end else begin
                    cmd.phase = PH_PAR2;
                end
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST) begin
                    round_next = '0;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.chain_add = 1'b1;
                state_next    = ret_reg;
            end
            S_DIGEST: begin
                // previous digest may still be draining
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/sha1_dp.sv
// ---------------------------------------------------------------------------
// SHA-1 datapath
// Block/schedule shift register, round logic, chaining value, digest output.
// ---------------------------------------------------------------------------
module sha1_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     s_tdata,
    input  sha1_pkg::cmd_t cmd,
    output sha1_pkg::sts_t sts,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,
    output logic           m_tlast
);
    import sha1_pkg::*;

    // 16-word window; word 0 (oldest) in the top bits
    logic [511:0] sr_reg, sr_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  h_reg [DIGEST_WORDS];
    logic [63:0]  len_reg;
    logic [159:0] dig_reg;
    logic         out_valid_reg;
    logic [2:0]   out_idx_reg;

    logic [7:0]   byte_in;
    logic [31:0]  w_cur, w_x, w_new, f_val, t_val;
    logic [5:0]   len_sh;

    assign len_sh = {~cmd.len_idx, 3'b000};

    always_comb begin
        case (cmd.byte_sel)
            SEL_INPUT: byte_in = s_tdata;
            SEL_PAD80: byte_in = PAD_MARKER;
            SEL_ZERO:  byte_in = 8'h00;
            SEL_LEN:   byte_in = len_reg[len_sh +: 8];
            default:   byte_in = 8'h00;
        endcase
    end

    assign w_cur = sr_reg[511:480];
    assign w_x   = sr_reg[95:64] ^ sr_reg[255:224] ^ sr_reg[447:416] ^ w_cur;
    assign w_new = {w_x[30:0], w_x[31]};

    always_comb begin
        case (cmd.phase)
            PH_CH:   f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            PH_MAJ:  f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + K_TABLE[cmd.phase] + w_cur;

    always_comb begin
        if (cmd.shift_en) begin
            sr_next = {sr_reg[503:0], byte_in};
        end else if (cmd.round_en) begin
            sr_next = {sr_reg[479:0], w_new};
        end else begin
            sr_next = sr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg <= sr_next;
        if (cmd.init_work) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (cmd.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.finish) begin
            dig_reg <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
        end else if (out_valid_reg && m_tready) begin
            dig_reg <= {dig_reg[127:0], 32'h0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg         <= H_INIT;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end else begin
            if (cmd.finish) begin
                h_reg   <= H_INIT;
                len_reg <= '0;
            end else begin
                if (cmd.chain_add) begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                if (cmd.len_add) begin
                    len_reg <= len_reg + 64'd8;
                end
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= '0;
            end else if (out_valid_reg && m_tready) begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == LAST_WORD_IDX) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.out_busy = out_valid_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {5'b00000, out_idx_reg, dig_reg[159:128]};
    assign m_tlast      = (out_idx_reg == LAST_WORD_IDX);

endmodule

FILE: design/sha1_hash_top.sv
// SHA-1 hasher, one message byte per request. A byte is accepted whenever the
// controller is idle; the 64th byte of a block starts the compression, which
// runs one round per cycle in the datapath round unit and blocks input for
// the 80 rounds plus the chaining update. An end request is followed by
// padding written byte by byte into the block register (one or two
// compressions), then the five digest words h0..h4 leave on the master side,
// one per request, while the next message may already stream in. No clearing
// pass after reset.
`include "assert_macros.svh"

// ---------------------------------------------------------------------------
// SHA-1 hash top level
// Byte-stream SHA-1 with digest output as five 32-bit words.
// ---------------------------------------------------------------------------
module sha1_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    import sha1_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sha1_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    sha1_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_ALWAYS(a_no_shift_in_round, aclk, aresetn, !(cmd.shift_en && cmd.round_en), "byte push during round")
    `ASSERT_IMPLIES(a_ready_not_busy, aclk, aresetn, s_tready, !cmd.round_en && !cmd.chain_add, "ready while compressing")
    `ASSERT_IMPLIES(a_finish_out_free, aclk, aresetn, cmd.finish, !sts.out_busy, "digest overwrites pending output")
    `ASSERT_NEXT(a_finish_emits_h0, aclk, aresetn, cmd.finish, m_tvalid && (m_tdata[34:32] == 3'd0), "digest does not start at h0")

endmodule

FILE: verif/sha1_hash_top_tb.sv
// ---------------------------------------------------------------------------
// SHA-1 hash top level testbench
// Streams messages into the hasher byte by byte and checks every digest word
// against a behavioural SHA-1 kept in the bench, or a known digest where the
// table gives one. A short table covers the empty message, a known short
// message, empty items and the byte extremes. Random messages follow, mostly
// short, one length in five on a padding boundary. Both sides idle at random.
// ---------------------------------------------------------------------------
module sha1_hash_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS  = 280;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha1_hash_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // One digest word as it should leave the master side
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    // Directed request; known_digest holds h0 in its top bits
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         msg_end;
        logic         use_known;
        logic [159:0] known_digest;
    } plan_row_t;

    localparam int PLAN_ROWS = 11;
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        // empty message straight after reset
        '{8'h00, 1'b0, 1'b1, 1'b1,
          160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
        // "abc", end flag on the last byte
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1,
          160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
        // empty item, data bits must be ignored
        '{8'ha5, 1'b0, 1'b0, 1'b0, 160'h0},
        // empty end item after bytes
        '{8'h5a, 1'b0, 1'b1, 1'b0, 160'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'hff, 1'b0, 1'b1, 1'b0, 160'h0}
    };

    localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    digest_word_t digest_q [$];
    int  fail_count  = 0;
    int  idle_cycles = 0;
    int  sent_count  = 0;
    bit  tx_steady   = 1'b0;
    bit  rx_steady   = 1'b0;

    // Bench copy of the hasher state
    logic [31:0] chain_v [5];
    logic [7:0]  block_buf [64];
    int          fill_cnt;
    logic [63:0] msg_bits;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        chain_v[0] = 32'h67452301;
        chain_v[1] = 32'hefcdab89;
        chain_v[2] = 32'h98badcfe;
        chain_v[3] = 32'h10325476;
        chain_v[4] = 32'hc3d2e1f0;
        fill_cnt   = 0;
        msg_bits   = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
        a = chain_v[0];
        b = chain_v[1];
        c = chain_v[2];
        d = chain_v[3];
        e = chain_v[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
                w[r & 15] = rotl32(x, 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end else begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = rotl32(a, 5) + f + e + k + w[r & 15];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_v[0] += a;
        chain_v[1] += b;
        chain_v[2] += c;
        chain_v[3] += d;
        chain_v[4] += e;
    endfunction

    function automatic void sha1_absorb(input logic [7:0] v);
        block_buf[fill_cnt] = v;
        fill_cnt++;
        if (fill_cnt == 64) begin
            sha1_compress();
            fill_cnt = 0;
        end
    endfunction

    // Advance the bench hasher by one accepted request, queueing digest words
    function automatic void sha1_take_item(input logic [7:0] data, input logic present,
                                           input logic msg_end, input logic use_known,
                                           input logic [159:0] known_digest);
        logic [63:0]  len;
        digest_word_t dw;
        int i;
        if (present) begin
            msg_bits += 64'd8;
            sha1_absorb(data);
        end
        if (msg_end) begin
            len = msg_bits;
            sha1_absorb(8'h80);
            while (fill_cnt != 56)
                sha1_absorb(8'h00);
            for (i = 0; i < 8; i++)
                sha1_absorb(len[63 - 8*i -: 8]);
            for (i = 0; i < 5; i++) begin
                dw.word  = use_known ? known_digest[159 - 32*i -: 32] : chain_v[i];
                dw.index = 3'(i);
                dw.last  = (i == 4);
                digest_q.push_back(dw);
            end
            sha1_restart();
        end
    endfunction

    // Present one request and hold it until the slave side takes it
    task automatic send_request(input logic [7:0] data, input logic present,
                                input logic msg_end, input logic use_known,
                                input logic [159:0] known_digest);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= msg_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sha1_take_item(data, present, msg_end, use_known, known_digest);
        sent_count++;
    endtask

    task automatic send_random(input logic present, input logic msg_end);
        // odd empty item between requests
        if ($urandom_range(0, 7) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'h0);
        send_request(8'($urandom_range(0, 255)), present, msg_end, 1'b0, 160'h0);
    endtask

    initial begin : stimulus
        int row;
        int msg_len;
        int b;
        bit end_on_byte;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        sha1_restart();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < PLAN_ROWS; row++)
            send_request(DIRECTED_PLAN[row].data, DIRECTED_PLAN[row].present,
                         DIRECTED_PLAN[row].msg_end, DIRECTED_PLAN[row].use_known,
                         DIRECTED_PLAN[row].known_digest);

        while (sent_count < TOTAL_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                msg_len = BOUNDARY_LENS[$urandom_range(0, 7)];
            else
                msg_len = $urandom_range(0, 12);
            end_on_byte = (msg_len > 0) && $urandom_range(0, 1);
            for (b = 0; b < msg_len; b++)
                send_random(1'b1, end_on_byte && (b == msg_len - 1));
            if (!end_on_byte)
                send_random(1'b0, 1'b1);
        end
        s_tvalid <= 1'b0;

        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("** sha1_hash_top: PASSED **");
        else
            $display("** sha1_hash_top: FAILED **");
        $finish;
    end

    initial begin : digest_sink
        int stall;
        int taken;
        digest_word_t want;
        m_tready <= 1'b0;
        taken = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (taken % 10 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            if (digest_q.size() == 0) begin
                $error("unexpected digest word %h index %0d", m_tdata[31:0], m_tdata[34:32]);
                fail_count++;
            end else begin
                want = digest_q.pop_front();
                if (m_tdata[31:0] !== want.word) begin
                    $error("digest_word: expected %h, got %h", want.word, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[34:32] !== want.index) begin
                    $error("word_index: expected %0d, got %0d", want.index, m_tdata[34:32]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_word: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Stall detector: no request moving on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** sha1_hash_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
